// ----- hw/rtl/dual_shelving_filter_8ch_top_defines.svh -----
// assertion macros for the dual shelving filter
// used by the top level only, no other dependencies
`ifndef DUAL_SHELVING_FILTER_8CH_TOP_DEFINES_SVH
`define DUAL_SHELVING_FILTER_8CH_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DSF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DSF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dsf_pkg.sv -----
// shared types and constants for the dual shelving filter
// no dependencies
`timescale 1ns / 1ps

package dsf_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CH_BITS    = 3;
    localparam int COEF_BITS  = 16;
    localparam int ALPHA_FRAC = 14;
    localparam int GAIN_FRAC  = 12;

    // apb register map, byte address = 4 * index
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_HIGH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_HIGH = 3'd4;

    localparam logic                        ENABLE_RST     = 1'b1;
    localparam logic signed [COEF_BITS-1:0] GAIN_LOW_RST   = 16'sd4096;
    localparam logic signed [COEF_BITS-1:0] GAIN_HIGH_RST  = 16'sd4096;
    localparam logic signed [COEF_BITS-1:0] ALPHA_LOW_RST  = 16'sd8192;
    localparam logic signed [COEF_BITS-1:0] ALPHA_HIGH_RST = -16'sd8192;

    // alpha limit of plus or minus one in q2.14
    localparam logic signed [COEF_BITS-1:0] ALPHA_ONE = 16'sd16384;

    typedef struct packed {
        logic                        enable;
        logic signed [COEF_BITS-1:0] gain_low;
        logic signed [COEF_BITS-1:0] gain_high;
        logic signed [COEF_BITS-1:0] alpha_low;
        logic signed [COEF_BITS-1:0] alpha_high;
    } t_cfg;

endpackage

// ----- hw/rtl/dsf_in_if.sv -----
// input sample channel: valid/ready with channel number and sample
// depends on dsf_pkg for the channel width and the default sample width
`timescale 1ns / 1ps

interface dsf_in_if #(
    parameter int SAMPLE_BITS = dsf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [dsf_pkg::CH_BITS-1:0]   channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// ----- hw/rtl/dsf_out_if.sv -----
// output sample channel: valid/ready with channel number and filtered sample
// depends on dsf_pkg for the channel width and the default sample width
`timescale 1ns / 1ps

interface dsf_out_if #(
    parameter int SAMPLE_BITS = dsf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [dsf_pkg::CH_BITS-1:0]   channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output channel_out, output sample_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

// ----- hw/rtl/dsf_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dsf_regs.sv -----
// apb configuration registers of the dual shelving filter
// depends on dsf_pkg for the register map and reset values
`timescale 1ns / 1ps

module dsf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsf_pkg::ADDR_W-1:0]   paddr,
    input  logic [dsf_pkg::DATA_W-1:0]   pwdata,
    output logic [dsf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output dsf_pkg::t_cfg                o_cfg
);
    import dsf_pkg::*;

    logic                        r_enable;
    logic signed [COEF_BITS-1:0] r_gain_low;
    logic signed [COEF_BITS-1:0] r_gain_high;
    logic signed [COEF_BITS-1:0] r_alpha_low;
    logic signed [COEF_BITS-1:0] r_alpha_high;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= ENABLE_RST;
            r_gain_low   <= GAIN_LOW_RST;
            r_gain_high  <= GAIN_HIGH_RST;
            r_alpha_low  <= ALPHA_LOW_RST;
            r_alpha_high <= ALPHA_HIGH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE:     r_enable     <= pwdata[0];
                REG_GAIN_LOW:   r_gain_low   <= pwdata[COEF_BITS-1:0];
                REG_GAIN_HIGH:  r_gain_high  <= pwdata[COEF_BITS-1:0];
                REG_ALPHA_LOW:  r_alpha_low  <= pwdata[COEF_BITS-1:0];
                REG_ALPHA_HIGH: r_alpha_high <= pwdata[COEF_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENABLE:     prdata = DATA_W'(r_enable);
            REG_GAIN_LOW:   prdata = DATA_W'(r_gain_low);
            REG_GAIN_HIGH:  prdata = DATA_W'(r_gain_high);
            REG_ALPHA_LOW:  prdata = DATA_W'(r_alpha_low);
            REG_ALPHA_HIGH: prdata = DATA_W'(r_alpha_high);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.enable     = r_enable;
    assign o_cfg.gain_low   = r_gain_low;
    assign o_cfg.gain_high  = r_gain_high;
    assign o_cfg.alpha_low  = r_alpha_low;
    assign o_cfg.alpha_high = r_alpha_high;

endmodule

// ----- hw/rtl/dual_shelving_filter_8ch_top.sv -----
// Dual first-order allpass shelving filter for up to CHANNELS interleaved channels.
// Each request runs a high-shelving stage and then a low-shelving stage; the per-channel
// history (previous input and allpass output of both stages) lives in one ram entry that is
// read when the request is taken and written back when its result is handed over, and a
// flop per channel marks entries not yet written since reset, which are read as zero. One
// request is worked on at a time, passing through S_RD and then S_AP, S_APF, S_ACC and S_Y
// once per stage before S_WB loads the output register when it is free; the single shared
// 16 x (SAMPLE_BITS+3) multiplier is used twice per stage. With enable off, or a channel not
// below CHANNELS, the sample goes straight to S_WB and passes unchanged into the output
// register, and the history is left alone. The output register lets a new request in
// while a result still waits to be taken.
// Depends on dsf_pkg, dsf_in_if, dsf_out_if, dsf_regs, dsf_ram and the defines header.
`timescale 1ns / 1ps
`include "dual_shelving_filter_8ch_top_defines.svh"

module dual_shelving_filter_8ch_top #(
    parameter int CHANNELS    = dsf_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = dsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dsf_in_if.sink                      i_in,
    dsf_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsf_pkg::ADDR_W-1:0]  paddr,
    input  logic [dsf_pkg::DATA_W-1:0]  pwdata,
    output logic [dsf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import dsf_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AP_W = SB + 2;
    localparam int S_W  = SB + 3;
    localparam int P_W  = S_W + COEF_BITS;
    localparam int A_W  = P_W + 1;
    localparam int T_W  = SB + 6;
    localparam int Q_W  = SB + 7;
    localparam int R_W  = P_W - ALPHA_FRAC;
    localparam int MEM_W = 2 * SB + 2 * AP_W;

    // field offsets in a history word
    localparam int HP_XP_LO = 0;
    localparam int HP_AP_LO = SB;
    localparam int LP_XP_LO = SB + AP_W;
    localparam int LP_AP_LO = 2 * SB + AP_W;

    localparam logic [4:0] CH_LIM = 5'(CHANNELS);

    localparam logic signed [P_W-1:0] RND_AP = P_W'(1 << (ALPHA_FRAC - 1));
    localparam logic signed [A_W-1:0] RND_Y  = A_W'(1 << GAIN_FRAC);

    localparam logic signed [T_W-1:0]  AP_MAX = {5'b0, {(SB + 1){1'b1}}};
    localparam logic signed [T_W-1:0]  AP_MIN = {{5{1'b1}}, {(SB + 1){1'b0}}};
    localparam logic signed [Q_W-1:0]  Y_MAX  = {8'b0, {(SB - 1){1'b1}}};
    localparam logic signed [Q_W-1:0]  Y_MIN  = {{8{1'b1}}, {(SB - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_AP,
        S_APF,
        S_ACC,
        S_Y,
        S_WB
    } t_state;

    t_cfg cfg;

    t_state                    r_state;
    logic                      r_stg;
    logic                      r_upd;
    logic [CH_BITS-1:0]        r_ch;
    logic [AW-1:0]             r_addr;
    logic signed [SB-1:0]      r_x;
    logic signed [SB-1:0]      r_hp_xp;
    logic signed [AP_W-1:0]    r_hp_ap;
    logic signed [SB-1:0]      r_lp_xp;
    logic signed [AP_W-1:0]    r_lp_ap;
    logic signed [P_W-1:0]     r_prod;
    logic signed [A_W-1:0]     r_base;
    logic signed [AP_W-1:0]    r_ap;
    logic [CHANNELS-1:0]       r_valid;
    logic                      r_out_valid;
    logic [CH_BITS-1:0]        r_out_ch;
    logic signed [SB-1:0]      r_out_sample;

    logic                      in_acc;
    logic                      bypass;
    logic [AW+CH_BITS-1:0]     ch_ext;
    logic [AW-1:0]             in_addr;
    logic                      out_free;
    logic                      out_load;
    logic                      ram_we;
    logic [MEM_W-1:0]          ram_wdata;
    logic [MEM_W-1:0]          ram_rdata;

    logic signed [COEF_BITS-1:0] alpha_raw;
    logic signed [COEF_BITS-1:0] alpha_clip;
    logic signed [COEF_BITS-1:0] gain_sel;
    logic signed [SB-1:0]        xp_sel;
    logic signed [AP_W-1:0]      app_sel;
    logic signed [S_W-1:0]       ap_in_sum;
    logic signed [S_W-1:0]       st_sum;
    logic signed [S_W-1:0]       st_diff;
    logic signed [COEF_BITS-1:0] mul_a;
    logic signed [S_W-1:0]       mul_b;
    logic signed [S_W-1:0]       base_sel;
    logic signed [P_W-1:0]       ap_rnd;
    logic signed [R_W-1:0]       ap_q;
    logic signed [T_W-1:0]       ap_t;
    logic signed [A_W-1:0]       y_acc;
    logic signed [A_W-1:0]       y_sh;
    logic signed [Q_W-1:0]       y_q;

    logic signed [P_W-1:0]       n_prod;
    logic signed [A_W-1:0]       n_base;
    logic signed [AP_W-1:0]      n_ap;
    logic signed [SB-1:0]        n_y;

    dsf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dsf_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // handshake and addressing
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign ch_ext     = (AW + CH_BITS)'(i_in.channel);
    assign in_addr    = ch_ext[AW-1:0];
    assign bypass     = !cfg.enable || !({2'b0, i_in.channel} < CH_LIM);

    assign out_free  = !r_out_valid || o_out.ready;
    assign out_load  = (r_state == S_WB) && out_free;
    assign ram_we    = out_load && r_upd;
    assign ram_wdata = {r_lp_ap, r_lp_xp, r_hp_ap, r_hp_xp};

    assign o_out.valid       = r_out_valid;
    assign o_out.channel_out = r_out_ch;
    assign o_out.sample_out  = r_out_sample;

    // stage operand selection, stage 0 is the high shelf
    always_comb begin
        alpha_raw = r_stg ? cfg.alpha_low : cfg.alpha_high;
        gain_sel  = r_stg ? cfg.gain_low : cfg.gain_high;
        xp_sel    = r_stg ? r_lp_xp : r_hp_xp;
        app_sel   = r_stg ? r_lp_ap : r_hp_ap;

        if (alpha_raw > ALPHA_ONE) begin
            alpha_clip = ALPHA_ONE;
        end else if (alpha_raw < -ALPHA_ONE) begin
            alpha_clip = -ALPHA_ONE;
        end else begin
            alpha_clip = alpha_raw;
        end

        ap_in_sum = S_W'(r_x) + S_W'(app_sel);
        st_sum    = S_W'(r_x) + S_W'(r_ap);
        st_diff   = S_W'(r_x) - S_W'(r_ap);
        // high shelf scales the sum by the gain, low shelf the difference
        base_sel  = r_stg ? st_sum : st_diff;
    end

    // shared multiplier
    always_comb begin
        if (r_state == S_ACC) begin
            mul_a = gain_sel;
            mul_b = r_stg ? st_diff : st_sum;
        end else begin
            mul_a = alpha_clip;
            mul_b = ap_in_sum;
        end
        n_prod = P_W'(mul_a) * P_W'(mul_b);
        n_base = A_W'(base_sel) <<< GAIN_FRAC;
    end

    // allpass output: round to sample scale, subtract previous input, saturate
    always_comb begin
        ap_rnd = (r_prod + RND_AP) >>> ALPHA_FRAC;
        ap_q   = ap_rnd[R_W-1:0];
        ap_t   = T_W'(ap_q) - T_W'(xp_sel);
        if (ap_t > AP_MAX) begin
            n_ap = {1'b0, {(AP_W - 1){1'b1}}};
        end else if (ap_t < AP_MIN) begin
            n_ap = {1'b1, {(AP_W - 1){1'b0}}};
        end else begin
            n_ap = ap_t[AP_W-1:0];
        end
    end

    // stage output: halve with rounding, saturate to full scale
    always_comb begin
        y_acc = A_W'(r_prod) + r_base;
        y_sh  = (y_acc + RND_Y) >>> (GAIN_FRAC + 1);
        y_q   = y_sh[Q_W-1:0];
        if (y_q > Y_MAX) begin
            n_y = {1'b0, {(SB - 1){1'b1}}};
        end else if (y_q < Y_MIN) begin
            n_y = {1'b1, {(SB - 1){1'b0}}};
        end else begin
            n_y = y_q[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch    <= i_in.channel;
                        r_x     <= i_in.sample_in;
                        r_addr  <= in_addr;
                        r_stg   <= 1'b0;
                        r_upd   <= !bypass;
                        r_state <= bypass ? S_WB : S_RD;
                    end
                end
                S_RD: begin
                    // entries never written read as zero
                    if (r_valid[r_addr]) begin
                        r_hp_xp <= ram_rdata[HP_XP_LO +: SB];
                        r_hp_ap <= ram_rdata[HP_AP_LO +: AP_W];
                        r_lp_xp <= ram_rdata[LP_XP_LO +: SB];
                        r_lp_ap <= ram_rdata[LP_AP_LO +: AP_W];
                    end else begin
                        r_hp_xp <= '0;
                        r_hp_ap <= '0;
                        r_lp_xp <= '0;
                        r_lp_ap <= '0;
                    end
                    r_state <= S_AP;
                end
                S_AP: begin
                    r_prod  <= n_prod;
                    r_state <= S_APF;
                end
                S_APF: begin
                    r_ap    <= n_ap;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_prod  <= n_prod;
                    r_base  <= n_base;
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_x <= n_y;
                    if (!r_stg) begin
                        r_hp_xp <= r_x;
                        r_hp_ap <= r_ap;
                        r_stg   <= 1'b1;
                        r_state <= S_AP;
                    end else begin
                        r_lp_xp <= r_x;
                        r_lp_ap <= r_ap;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_out_ch     <= r_ch;
                        r_out_sample <= r_x;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `DSF_ASSERT_NXT(a_acc_next, i_clk, i_rst_n, in_acc, (r_state == S_RD) || (r_state == S_WB), "request did not start")
    `DSF_ASSERT_IMP(a_wb_with_out, i_clk, i_rst_n, ram_we, out_load, "history written without result")
    `DSF_ASSERT_NXT(a_load_done, i_clk, i_rst_n, out_load, (r_state == S_IDLE) && o_out.valid, "result not presented")

endmodule
